FILE: rtl/toc_pkg.sv
package toc_pkg;

  // Sample and fixed-point formats
  localparam int SAMPLE_BITS   = 16;
  localparam int FRAC_IN       = 8;
  localparam int CORDIC_SHIFT  = 24;
  localparam int CORDIC_STEPS  = 20;
  localparam int ANGLE_FRAC    = 16;
  localparam int ANGLE_BIAS    = 32;

  localparam int MAG_W   = SAMPLE_BITS;
  localparam int Q_W     = MAG_W + FRAC_IN;
  localparam int SUM_W   = 2 * SAMPLE_BITS;
  localparam int RT_W    = (SUM_W + 2 * FRAC_IN + 1) / 2;
  localparam int RAD_W   = 2 * RT_W;
  localparam int REM_W   = RT_W + 2;
  localparam int CW      = RT_W + CORDIC_SHIFT + 3;
  localparam int TW      = ANGLE_FRAC + 10;
  localparam int STEP_W  = $clog2(CORDIC_STEPS);
  localparam int SQRT_STEPS = RT_W;

  localparam logic signed [TW-1:0] T90  = TW'(90 * (2 ** ANGLE_FRAC));
  localparam logic signed [TW-1:0] T180 = TW'(180 * (2 ** ANGLE_FRAC));

  typedef enum logic [2:0] {
    ORIENT_NORMAL      = 3'd0,
    ORIENT_RIGHT       = 3'd1,
    ORIENT_LEFT        = 3'd2,
    ORIENT_UPSIDE_DOWN = 3'd3,
    ORIENT_UP          = 3'd4,
    ORIENT_DOWN        = 3'd5
  } orient_t;

  typedef struct packed {
    logic signed [15:0] accel_x_sample;
    logic signed [15:0] accel_y_sample;
    logic signed [15:0] accel_z_sample;
  } sample_t;

  typedef struct packed {
    logic signed [8:0] roll_degrees;
    logic signed [7:0] pitch_degrees;
    orient_t           orientation;
  } result_t;

  // Square-root cell state
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    logic [REM_W-1:0] rem;
    logic [RT_W-1:0]  root;
  } sqrt_t;

  // CORDIC cell state
  typedef struct packed {
    logic signed [CW-1:0] cx;
    logic signed [CW-1:0] cy;
    logic signed [TW-1:0] t;
  } cordic_t;

  // Quadrant and special-case flags for both angles
  typedef struct packed {
    logic roll_zero;
    logic roll_yneg;
    logic roll_xneg;
    logic pitch_zero;
    logic pitch_yneg;
  } flag_t;

  typedef struct packed {
    flag_t          flags;
    logic [Q_W-1:0] roll_ay;
    logic [Q_W-1:0] roll_ax;
    logic [Q_W-1:0] pitch_ay;
  } side_t;

  // atan(2^-i) in Q16 degrees
  function automatic logic signed [TW-1:0] atan_q16(logic [STEP_W-1:0] i);
    case (i)
      5'd0:    atan_q16 = TW'(2949120);
      5'd1:    atan_q16 = TW'(1740967);
      5'd2:    atan_q16 = TW'(919879);
      5'd3:    atan_q16 = TW'(466945);
      5'd4:    atan_q16 = TW'(234379);
      5'd5:    atan_q16 = TW'(117265);
      5'd6:    atan_q16 = TW'(58666);
      5'd7:    atan_q16 = TW'(29335);
      5'd8:    atan_q16 = TW'(14668);
      5'd9:    atan_q16 = TW'(7334);
      5'd10:   atan_q16 = TW'(3667);
      5'd11:   atan_q16 = TW'(1833);
      5'd12:   atan_q16 = TW'(917);
      5'd13:   atan_q16 = TW'(458);
      5'd14:   atan_q16 = TW'(229);
      5'd15:   atan_q16 = TW'(115);
      5'd16:   atan_q16 = TW'(57);
      5'd17:   atan_q16 = TW'(29);
      5'd18:   atan_q16 = TW'(14);
      5'd19:   atan_q16 = TW'(7);
      default: atan_q16 = '0;
    endcase
  endfunction

endpackage

FILE: rtl/toc_sqrt_cell.sv
module toc_sqrt_cell (
  input  logic           clk,
  input  logic           en,
  input  toc_pkg::sqrt_t din,
  output toc_pkg::sqrt_t dout
);
  import toc_pkg::*;

  logic [REM_W-1:0] rem_sh;
  logic [REM_W-1:0] trial;
  logic             ge;
  sqrt_t            nxt;

  // One root bit: bring down two radicand bits, try subtracting 4q+1
  always_comb begin
    rem_sh   = {din.rem[REM_W-3:0], din.rad[RAD_W-1 -: 2]};
    trial    = {din.root, 2'b01};
    ge       = (rem_sh >= trial);
    nxt.rem  = ge ? (rem_sh - trial) : rem_sh;
    nxt.root = {din.root[RT_W-2:0], ge};
    nxt.rad  = {din.rad[RAD_W-3:0], 2'b00};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: rtl/toc_cordic_cell.sv
module toc_cordic_cell (
  input  logic                         clk,
  input  logic                         en,
  input  logic [toc_pkg::STEP_W-1:0]   step,
  input  toc_pkg::cordic_t             din,
  output toc_pkg::cordic_t             dout
);
  import toc_pkg::*;

  logic signed [CW-1:0] dx;
  logic signed [CW-1:0] dy;
  logic signed [TW-1:0] a;
  cordic_t              nxt;

  // Vectoring rotation: drive cy toward zero
  always_comb begin
    dx = din.cy >>> step;
    dy = din.cx >>> step;
    a  = atan_q16(step);
    if (!din.cy[CW-1]) begin
      nxt.cx = din.cx + dx;
      nxt.cy = din.cy - dy;
      nxt.t  = din.t + a;
    end else begin
      nxt.cx = din.cx - dx;
      nxt.cy = din.cy + dy;
      nxt.t  = din.t - a;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dout <= nxt;
    end
  end

endmodule

FILE: rtl/tilt_orientation_classifier_unit.sv
// Channel  | Handshake                     | Payload
// sample   | sample_valid / sample_ready   | toc_pkg::sample_t (x, y, z)
// result   | result_valid / result_ready   | toc_pkg::result_t (roll, pitch, orientation)
//
// One sample accepted per cycle unless the output stalls; each sample passes the magnitude
// stage, square stage, 24 square-root cells, 20 CORDIC cells per angle, output register.
// Rate is set by the cell chain, which moves one step every cycle unless the output stalls.
// When a result waits untaken, the whole chain holds and sample_ready is low.
// rst clears the valid bits only; no state survives between samples.
module tilt_orientation_classifier_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              sample_valid,
  output logic              sample_ready,
  input  toc_pkg::sample_t  sample,
  output logic              result_valid,
  input  logic              result_ready,
  output toc_pkg::result_t  result
);
  import toc_pkg::*;

  localparam int NST = 2 + SQRT_STEPS + CORDIC_STEPS;

  logic                 en;
  logic [NST-1:0]       vld;

  logic signed [SAMPLE_BITS-1:0] xs, ys, zs;
  logic [MAG_W-1:0]     axm_c, aym_c, azm_c;
  logic [MAG_W-1:0]     axm, azm;
  side_t                side_a, side_b, side_c;
  logic [SUM_W-1:0]     sum_b;

  sqrt_t                sq [SQRT_STEPS+1];
  side_t                side_s [SQRT_STEPS+1];
  cordic_t              rc [CORDIC_STEPS+1];
  cordic_t              pc [CORDIC_STEPS+1];
  flag_t                fl [CORDIC_STEPS+1];
  result_t              result_next;

  assign en           = !result_valid || result_ready;
  assign sample_ready = en;

  // Magnitudes and quadrant flags
  always_comb begin
    xs    = sample.accel_x_sample[SAMPLE_BITS-1:0];
    ys    = sample.accel_y_sample[SAMPLE_BITS-1:0];
    zs    = sample.accel_z_sample[SAMPLE_BITS-1:0];
    axm_c = MAG_W'(xs[SAMPLE_BITS-1] ? -xs : xs);
    aym_c = MAG_W'(ys[SAMPLE_BITS-1] ? -ys : ys);
    azm_c = MAG_W'(zs[SAMPLE_BITS-1] ? -zs : zs);
    side_c.flags.roll_zero  = (xs == '0);
    side_c.flags.roll_yneg  = !xs[SAMPLE_BITS-1] && (xs != '0);
    side_c.flags.roll_xneg  = zs[SAMPLE_BITS-1];
    side_c.flags.pitch_zero = (ys == '0);
    side_c.flags.pitch_yneg = ys[SAMPLE_BITS-1];
    side_c.roll_ay  = {axm_c, {FRAC_IN{1'b0}}};
    side_c.roll_ax  = {azm_c, {FRAC_IN{1'b0}}};
    side_c.pitch_ay = {aym_c, {FRAC_IN{1'b0}}};
  end

  // Valid shift line
  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      result_valid <= 1'b0;
    end else if (en) begin
      vld          <= {vld[NST-2:0], sample_valid && sample_ready};
      result_valid <= vld[NST-1];
    end
  end

  // Magnitude and sum-of-squares stages
  always_ff @(posedge clk) begin
    if (en) begin
      side_a <= side_c;
      axm    <= axm_c;
      azm    <= azm_c;
      side_b <= side_a;
      sum_b  <= (SUM_W'(axm) * SUM_W'(axm)) + (SUM_W'(azm) * SUM_W'(azm));
    end
  end

  // Square-root chain
  assign sq[0].rad  = RAD_W'({sum_b, {(2*FRAC_IN){1'b0}}});
  assign sq[0].rem  = '0;
  assign sq[0].root = '0;
  assign side_s[0]  = side_b;

  for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
    toc_sqrt_cell u_cell (
      .clk  (clk),
      .en   (en),
      .din  (sq[g]),
      .dout (sq[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        side_s[g+1] <= side_s[g];
      end
    end
  end

  // CORDIC chains, roll and pitch side by side
  assign rc[0].cx = {{(CW-Q_W-CORDIC_SHIFT){1'b0}}, side_s[SQRT_STEPS].roll_ax,
                     {CORDIC_SHIFT{1'b0}}};
  assign rc[0].cy = {{(CW-Q_W-CORDIC_SHIFT){1'b0}}, side_s[SQRT_STEPS].roll_ay,
                     {CORDIC_SHIFT{1'b0}}};
  assign rc[0].t  = '0;
  assign pc[0].cx = {{(CW-RT_W-CORDIC_SHIFT){1'b0}}, sq[SQRT_STEPS].root,
                     {CORDIC_SHIFT{1'b0}}};
  assign pc[0].cy = {{(CW-Q_W-CORDIC_SHIFT){1'b0}}, side_s[SQRT_STEPS].pitch_ay,
                     {CORDIC_SHIFT{1'b0}}};
  assign pc[0].t  = '0;
  assign fl[0]    = side_s[SQRT_STEPS].flags;

  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    toc_cordic_cell u_roll (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(g)),
      .din  (rc[g]),
      .dout (rc[g+1])
    );
    toc_cordic_cell u_pitch (
      .clk  (clk),
      .en   (en),
      .step (STEP_W'(g)),
      .din  (pc[g]),
      .dout (pc[g+1])
    );
    always_ff @(posedge clk) begin
      if (en) begin
        fl[g+1] <= fl[g];
      end
    end
  end

  // Clamp, fold into the quadrant, bias and truncate to whole degrees
  function automatic logic signed [8:0] finish(logic signed [TW-1:0] t, logic zero,
                                               logic yneg, logic xneg);
    logic signed [TW-1:0] tc;
    logic [8:0]           mag;
    logic signed [8:0]    res;
    tc = t;
    if (tc < 0) tc = '0;
    if (tc > T90) tc = T90;
    if (xneg) tc = T180 - tc;
    tc  = tc + TW'(ANGLE_BIAS);
    mag = 9'(tc >>> ANGLE_FRAC);
    if (mag > 9'd180) mag = 9'd180;
    res = yneg ? -$signed(mag) : $signed(mag);
    if (zero) res = xneg ? -9'sd180 : 9'sd0;
    return res;
  endfunction

  function automatic orient_t classify(logic signed [8:0] roll, logic signed [7:0] pitch);
    int      r;
    int      p;
    orient_t o;
    r = int'(roll);
    p = int'(pitch);
    o = ORIENT_NORMAL;
    if (p > -50 && p < 50 && r > -120 && r < -60)    o = ORIENT_DOWN;
    else if (p > -50 && p < 50 && r > 50 && r < 120) o = ORIENT_UP;
    else if (p > -50 && p < 50 && r > -25 && r < 25) o = ORIENT_LEFT;
    else if (p > -50 && p < 50 && (r > 150 || r < -150)) o = ORIENT_RIGHT;
    else if (p < -55) o = ORIENT_UPSIDE_DOWN;
    return o;
  endfunction

  // Output register
  always_comb begin
    result_next.roll_degrees  = finish(rc[CORDIC_STEPS].t, fl[CORDIC_STEPS].roll_zero,
                                       fl[CORDIC_STEPS].roll_yneg,
                                       fl[CORDIC_STEPS].roll_xneg);
    result_next.pitch_degrees = 8'(finish(pc[CORDIC_STEPS].t, fl[CORDIC_STEPS].pitch_zero,
                                          fl[CORDIC_STEPS].pitch_yneg, 1'b0));
    result_next.orientation   = classify(result_next.roll_degrees,
                                         result_next.pitch_degrees);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result <= result_next;
    end
  end

`ifndef SYNTH
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("valid line moved during a stall");
  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.roll_degrees >= -9'sd180 && result.roll_degrees <= 9'sd180))
    else $error("roll out of range");
  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (result.pitch_degrees >= -8'sd90 && result.pitch_degrees <= 8'sd90))
    else $error("pitch out of range");
  a_feed: assert property (@(posedge clk) disable iff (rst)
    (en && vld[NST-1]) |=> result_valid)
    else $error("finished request dropped at output");
`endif

endmodule
